// ===== src/zpc_pkg.sv =====
// Shared types, constants and helpers for the ZMP preview controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package zpc_pkg;

    localparam int PREVIEW_DEPTH_DEF = 512;
    localparam int W = 48;

    // request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PUSH = 2'd1;
    localparam logic [1:0] REQ_STEP = 2'd2;

    // configuration register indexes
    localparam logic [3:0] CFG_KP  = 4'd0;
    localparam logic [3:0] CFG_KV  = 4'd1;
    localparam logic [3:0] CFG_KA  = 4'd2;
    localparam logic [3:0] CFG_KS  = 4'd3;
    localparam logic [3:0] CFG_T   = 4'd4;
    localparam logic [3:0] CFG_T2H = 4'd5;
    localparam logic [3:0] CFG_T3S = 4'd6;
    localparam logic [3:0] CFG_HC  = 4'd7;

    // multiplier phases
    localparam logic [2:0] PH_FETCH = 3'd0;
    localparam logic [2:0] PH_OPER  = 3'd1;
    localparam logic [2:0] PH_MUL0  = 3'd2;
    localparam logic [2:0] PH_MUL1  = 3'd3;
    localparam logic [2:0] PH_MUL2  = 3'd4;
    localparam logic [2:0] PH_MUL3  = 3'd5;
    localparam logic [2:0] PH_ROUND = 3'd6;
    localparam logic [2:0] PH_ACCUM = 3'd7;

    localparam logic [3:0] TERM_PREVIEW = 4'd4;
    localparam logic [3:0] TERM_LAST    = 4'd11;

    localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
    localparam logic signed [63:0] MIN48 = -64'sd140737488355328;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RUN, S_COMMIT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        A_KP, A_KV, A_KA, A_KS, A_GAIN, A_T, A_T2H, A_T3S, A_HC
    } t_asel;

    typedef enum logic [2:0] {
        B_POS, B_VEL, B_ACC, B_ESUM, B_WIN, B_U, B_NACC
    } t_bsel;

    typedef enum logic [2:0] {
        L_KEEP, L_ZERO, L_POS, L_VEL, L_ACC, L_NPOS
    } t_load;

    typedef enum logic [2:0] {
        ST_NONE, ST_U, ST_NPOS, ST_NVEL, ST_NACC, ST_ZMP
    } t_store;

    typedef struct packed {
        t_asel  a;
        t_bsel  b;
        logic   frac46;   // timing coefficient: drop 46 bits, else 24
        logic   sub;      // subtract product from accumulator
        t_load  ld;       // accumulator preload at operand phase
        t_store st;       // saturated accumulator goes here after the term
    } t_term;

    function automatic t_term term_desc(input logic [3:0] idx);
        t_term d;
        d = '{a: A_KP, b: B_POS, frac46: 1'b0, sub: 1'b0, ld: L_KEEP, st: ST_NONE};
        unique case (idx)
            4'd0:  d = '{A_KP,   B_POS,  1'b0, 1'b1, L_ZERO, ST_NONE};
            4'd1:  d = '{A_KV,   B_VEL,  1'b0, 1'b1, L_KEEP, ST_NONE};
            4'd2:  d = '{A_KA,   B_ACC,  1'b0, 1'b1, L_KEEP, ST_NONE};
            4'd3:  d = '{A_KS,   B_ESUM, 1'b0, 1'b0, L_KEEP, ST_NONE};
            4'd4:  d = '{A_GAIN, B_WIN,  1'b0, 1'b0, L_KEEP, ST_U};
            4'd5:  d = '{A_T,    B_VEL,  1'b1, 1'b0, L_POS,  ST_NONE};
            4'd6:  d = '{A_T2H,  B_ACC,  1'b1, 1'b0, L_KEEP, ST_NONE};
            4'd7:  d = '{A_T3S,  B_U,    1'b1, 1'b0, L_KEEP, ST_NPOS};
            4'd8:  d = '{A_T,    B_ACC,  1'b1, 1'b0, L_VEL,  ST_NONE};
            4'd9:  d = '{A_T2H,  B_U,    1'b1, 1'b0, L_KEEP, ST_NVEL};
            4'd10: d = '{A_T,    B_U,    1'b1, 1'b0, L_ACC,  ST_NACC};
            4'd11: d = '{A_HC,   B_NACC, 1'b0, 1'b0, L_NPOS, ST_ZMP};
            default: d = '{A_KP, B_POS, 1'b0, 1'b0, L_KEEP, ST_NONE};
        endcase
        return d;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > MAX48) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < MIN48) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/zmp_preview_controller_core.sv =====
// Two-axis cart-table ZMP preview controller, sequenced over one shared multiplier.
// Depends on zpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Input channel (i_valid / o_stall): one request per accept. req_type 0 writes a
//  preview gain, 1 appends a (ref_x, ref_y) reference to the ring window, 2 appends
//  one and runs a control step on both axes. Code 3 is dropped.
//  Output channel (o_valid / i_stall): one result per step request: new CoM
//  position, velocity, acceleration and ZMP for x and y.
//  Config channel (i_cfg_valid / o_cfg_ready): always ready; write only while idle.
//  Timing: load and push requests complete without leaving idle. A step drives every
//  product through one 24x24 multiplier in phases (operand fetch, magnitude, four
//  partial products, round, accumulate). Each axis runs PREVIEW_DEPTH + 11
//  products plus a commit state, and the step then ends in the done state.
//  Reset: after i_rst_n releases, a clearing pass zeroes the gain and window
//  memories; o_stall stays high during it.
//  Stall: a finished result sits in the output register; the block keeps taking
//  requests meanwhile, and a following step waits at its end until that result
//  is taken.
module zmp_preview_controller_core #(
    parameter int PREVIEW_DEPTH = zpc_pkg::PREVIEW_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [8:0]         i_gain_index,
    input  wire logic signed [47:0] i_gain_value,
    input  wire logic signed [47:0] i_ref_x,
    input  wire logic signed [47:0] i_ref_y,
    input  wire logic               i_integrate_error,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [47:0]      o_com_pos_x,
    output logic signed [47:0]      o_com_vel_x,
    output logic signed [47:0]      o_com_acc_x,
    output logic signed [47:0]      o_com_pos_y,
    output logic signed [47:0]      o_com_vel_y,
    output logic signed [47:0]      o_com_acc_y,
    output logic signed [47:0]      o_zmp_x,
    output logic signed [47:0]      o_zmp_y,
    // config channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [47:0]        i_cfg_data
);

    localparam int IW = (PREVIEW_DEPTH > 1) ? $clog2(PREVIEW_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PREVIEW_DEPTH - 1);

    zpc_pkg::t_state r_state, n_state;

    // config registers
    logic signed [47:0] r_kp, r_kv, r_ka, r_ks, r_hc;
    logic [46:0]        r_t, r_t2h, r_t3s;

    // cart state
    logic signed [47:0] r_pos_x, r_vel_x, r_acc_x, r_esum_x;
    logic signed [47:0] r_pos_y, r_vel_y, r_acc_y, r_esum_y;
    logic signed [47:0] r_zmp_x, r_zmp_y;

    // sequencer
    logic [2:0]    r_ph;
    logic [3:0]    r_term;
    logic          r_axis;
    logic          r_integ;
    logic [IW-1:0] r_i, r_ptr, r_head, r_clr;

    // datapath
    logic [47:0]        r_ma, r_mb;
    logic               r_pneg;
    logic [95:0]        r_prod;
    logic [48:0]        r_mag;
    logic signed [63:0] r_acc;
    logic signed [47:0] r_u, r_npos, r_nvel, r_nacc, r_zmp, r_old;

    // result register
    logic               r_ovalid;
    logic signed [47:0] r_o_pos_x, r_o_vel_x, r_o_acc_x;
    logic signed [47:0] r_o_pos_y, r_o_vel_y, r_o_acc_y, r_o_zmp_x, r_o_zmp_y;

    // memories
    logic signed [47:0] gain_mem [PREVIEW_DEPTH];
    logic signed [47:0] winx_mem [PREVIEW_DEPTH];
    logic signed [47:0] winy_mem [PREVIEW_DEPTH];
    logic signed [47:0] r_gain_rd, r_winx_rd, r_winy_rd;

    logic accept, step_go, cfg_we;
    logic gain_we, win_we;
    logic [IW-1:0] gain_waddr, win_waddr;
    logic signed [47:0] gain_wdata, winx_wdata, winy_wdata;

    zpc_pkg::t_term desc;
    logic signed [47:0] a_val, b_val, cur_pos, cur_vel, cur_acc, cur_esum, ld_val;
    logic [47:0]  a_mag, b_mag;
    logic [23:0]  ha, hb;
    logic [47:0]  pp;
    logic [95:0]  pp_sh;
    logic [96:0]  rsum, rshift;
    logic signed [47:0] prod_s;
    logic signed [63:0] acc_n;
    logic signed [47:0] acc_sat, esum_n;
    logic last_prev;

    assign o_stall     = (r_state != zpc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_com_pos_x = r_o_pos_x;
    assign o_com_vel_x = r_o_vel_x;
    assign o_com_acc_x = r_o_acc_x;
    assign o_com_pos_y = r_o_pos_y;
    assign o_com_vel_y = r_o_vel_y;
    assign o_com_acc_y = r_o_acc_y;
    assign o_zmp_x     = r_o_zmp_x;
    assign o_zmp_y     = r_o_zmp_y;

    assign accept  = i_valid && (r_state == zpc_pkg::S_IDLE);
    assign step_go = accept && (i_req_type == zpc_pkg::REQ_STEP);
    assign cfg_we  = i_cfg_valid;
    assign desc    = zpc_pkg::term_desc(r_term);
    assign last_prev = (r_term != zpc_pkg::TERM_PREVIEW) || (r_i == LAST_IDX);

    // memory write ports: clearing pass or accepted request
    always_comb begin
        gain_we    = 1'b0;
        win_we     = 1'b0;
        gain_waddr = r_clr;
        win_waddr  = r_clr;
        gain_wdata = '0;
        winx_wdata = '0;
        winy_wdata = '0;
        if (r_state == zpc_pkg::S_CLEAR) begin
            gain_we = 1'b1;
            win_we  = 1'b1;
        end else if (accept) begin
            if (i_req_type == zpc_pkg::REQ_LOAD && 32'(i_gain_index) < PREVIEW_DEPTH) begin
                gain_we    = 1'b1;
                gain_waddr = IW'(i_gain_index);
                gain_wdata = i_gain_value;
            end
            if (i_req_type == zpc_pkg::REQ_PUSH || i_req_type == zpc_pkg::REQ_STEP) begin
                win_we     = 1'b1;
                win_waddr  = r_head;
                winx_wdata = i_ref_x;
                winy_wdata = i_ref_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (gain_we) begin
            gain_mem[gain_waddr] <= gain_wdata;
        end
        r_gain_rd <= gain_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            winx_mem[win_waddr] <= winx_wdata;
            winy_mem[win_waddr] <= winy_wdata;
        end
        r_winx_rd <= winx_mem[r_ptr];
        r_winy_rd <= winy_mem[r_ptr];
    end

    // operand selection for the current term
    always_comb begin
        cur_pos  = r_axis ? r_pos_y  : r_pos_x;
        cur_vel  = r_axis ? r_vel_y  : r_vel_x;
        cur_acc  = r_axis ? r_acc_y  : r_acc_x;
        cur_esum = r_axis ? r_esum_y : r_esum_x;
        case (desc.a)
            zpc_pkg::A_KP:   a_val = r_kp;
            zpc_pkg::A_KV:   a_val = r_kv;
            zpc_pkg::A_KA:   a_val = r_ka;
            zpc_pkg::A_KS:   a_val = r_ks;
            zpc_pkg::A_GAIN: a_val = r_gain_rd;
            zpc_pkg::A_T:    a_val = $signed({1'b0, r_t});
            zpc_pkg::A_T2H:  a_val = $signed({1'b0, r_t2h});
            zpc_pkg::A_T3S:  a_val = $signed({1'b0, r_t3s});
            default:         a_val = r_hc;
        endcase
        case (desc.b)
            zpc_pkg::B_POS:  b_val = cur_pos;
            zpc_pkg::B_VEL:  b_val = cur_vel;
            zpc_pkg::B_ACC:  b_val = cur_acc;
            zpc_pkg::B_ESUM: b_val = cur_esum;
            zpc_pkg::B_WIN:  b_val = r_axis ? r_winy_rd : r_winx_rd;
            zpc_pkg::B_U:    b_val = r_u;
            default:         b_val = r_nacc;
        endcase
        case (desc.ld)
            zpc_pkg::L_POS:  ld_val = cur_pos;
            zpc_pkg::L_VEL:  ld_val = cur_vel;
            zpc_pkg::L_ACC:  ld_val = cur_acc;
            zpc_pkg::L_NPOS: ld_val = r_npos;
            default:         ld_val = '0;
        endcase
        a_mag = a_val[47] ? 48'(-a_val) : 48'(a_val);
        b_mag = b_val[47] ? 48'(-b_val) : 48'(b_val);
    end

    // one 24x24 partial product per cycle
    always_comb begin
        case (r_ph)
            zpc_pkg::PH_MUL0: begin ha = r_ma[23:0];  hb = r_mb[23:0];  end
            zpc_pkg::PH_MUL1: begin ha = r_ma[23:0];  hb = r_mb[47:24]; end
            zpc_pkg::PH_MUL2: begin ha = r_ma[47:24]; hb = r_mb[23:0];  end
            default:          begin ha = r_ma[47:24]; hb = r_mb[47:24]; end
        endcase
        pp = ha * hb;
        case (r_ph)
            zpc_pkg::PH_MUL0:                   pp_sh = {48'b0, pp};
            zpc_pkg::PH_MUL1, zpc_pkg::PH_MUL2: pp_sh = {24'b0, pp, 24'b0};
            default:                            pp_sh = {pp, 48'b0};
        endcase
    end

    // round to nearest (ties away), then signed saturate and accumulate
    always_comb begin
        rsum   = {1'b0, r_prod} + (desc.frac46 ? (97'd1 << 45) : (97'd1 << 23));
        rshift = desc.frac46 ? (rsum >> 46) : (rsum >> 24);
        if (r_pneg) begin
            prod_s = (r_mag > 49'h0_8000_0000_0000) ? 48'sh8000_0000_0000
                                                    : 48'(-$signed({1'b0, r_mag[47:0]}));
        end else begin
            prod_s = (r_mag > 49'h0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                                                    : $signed(r_mag[47:0]);
        end
        acc_n   = desc.sub ? (r_acc - 64'(prod_s)) : (r_acc + 64'(prod_s));
        acc_sat = zpc_pkg::sat48(acc_n);
        esum_n  = zpc_pkg::sat48(64'(cur_esum) + 64'(r_old) - 64'(r_zmp));
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zpc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            zpc_pkg::S_CLEAR: begin
                if (r_clr == LAST_IDX) n_state = zpc_pkg::S_IDLE;
            end
            zpc_pkg::S_IDLE: begin
                if (step_go) n_state = zpc_pkg::S_RUN;
            end
            zpc_pkg::S_RUN: begin
                if (r_ph == zpc_pkg::PH_ACCUM && r_term == zpc_pkg::TERM_LAST)
                    n_state = zpc_pkg::S_COMMIT;
            end
            zpc_pkg::S_COMMIT: begin
                n_state = r_axis ? zpc_pkg::S_DONE : zpc_pkg::S_RUN;
            end
            zpc_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) n_state = zpc_pkg::S_IDLE;
            end
            default: n_state = zpc_pkg::S_IDLE;
        endcase
    end

    // control and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_kv <= '0; r_ka <= '0; r_ks <= '0; r_hc <= '0;
            r_t <= '0; r_t2h <= '0; r_t3s <= '0;
            r_pos_x <= '0; r_vel_x <= '0; r_acc_x <= '0; r_esum_x <= '0;
            r_pos_y <= '0; r_vel_y <= '0; r_acc_y <= '0; r_esum_y <= '0;
            r_zmp_x <= '0; r_zmp_y <= '0;
            r_ph <= zpc_pkg::PH_FETCH;
            r_term <= '0;
            r_axis <= 1'b0;
            r_integ <= 1'b0;
            r_i <= '0; r_ptr <= '0; r_head <= '0; r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (i_cfg_index)
                    zpc_pkg::CFG_KP:  r_kp  <= $signed(i_cfg_data);
                    zpc_pkg::CFG_KV:  r_kv  <= $signed(i_cfg_data);
                    zpc_pkg::CFG_KA:  r_ka  <= $signed(i_cfg_data);
                    zpc_pkg::CFG_KS:  r_ks  <= $signed(i_cfg_data);
                    zpc_pkg::CFG_T:   r_t   <= i_cfg_data[46:0];
                    zpc_pkg::CFG_T2H: r_t2h <= i_cfg_data[46:0];
                    zpc_pkg::CFG_T3S: r_t3s <= i_cfg_data[46:0];
                    zpc_pkg::CFG_HC:  r_hc  <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // new result loads when the register is free or being taken
            if (r_state == zpc_pkg::S_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                zpc_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                zpc_pkg::S_IDLE: begin
                    if (win_we) begin
                        r_head <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                        r_ptr  <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    end
                    if (step_go) begin
                        r_integ <= i_integrate_error;
                        r_axis  <= 1'b0;
                        r_term  <= '0;
                        r_i     <= '0;
                        r_ph    <= zpc_pkg::PH_FETCH;
                    end
                end
                zpc_pkg::S_RUN: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == zpc_pkg::PH_ACCUM) begin
                        if (!last_prev) begin
                            r_i   <= r_i + 1'b1;
                            r_ptr <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                        end else if (r_term != zpc_pkg::TERM_LAST) begin
                            r_term <= r_term + 1'b1;
                        end
                    end
                end
                zpc_pkg::S_COMMIT: begin
                    if (r_axis) begin
                        r_pos_y <= r_npos; r_vel_y <= r_nvel; r_acc_y <= r_nacc;
                        r_zmp_y <= r_zmp;
                        if (r_integ) r_esum_y <= esum_n;
                    end else begin
                        r_pos_x <= r_npos; r_vel_x <= r_nvel; r_acc_x <= r_nacc;
                        r_zmp_x <= r_zmp;
                        if (r_integ) r_esum_x <= esum_n;
                    end
                    r_axis <= 1'b1;
                    r_term <= '0;
                    r_i    <= '0;
                    r_ptr  <= r_head;
                    r_ph   <= zpc_pkg::PH_FETCH;
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == zpc_pkg::S_RUN) begin
            case (r_ph)
                zpc_pkg::PH_OPER: begin
                    r_ma   <= a_mag;
                    r_mb   <= b_mag;
                    r_pneg <= a_val[47] ^ b_val[47];
                    r_prod <= '0;
                    if (desc.ld != zpc_pkg::L_KEEP) r_acc <= 64'(ld_val);
                    if (r_term == zpc_pkg::TERM_PREVIEW && r_i == '0)
                        r_old <= r_axis ? r_winy_rd : r_winx_rd;
                end
                zpc_pkg::PH_MUL0, zpc_pkg::PH_MUL1,
                zpc_pkg::PH_MUL2, zpc_pkg::PH_MUL3: begin
                    r_prod <= r_prod + pp_sh;
                end
                zpc_pkg::PH_ROUND: begin
                    r_mag <= (|rshift[96:48]) ? 49'h1_0000_0000_0000 : {1'b0, rshift[47:0]};
                end
                zpc_pkg::PH_ACCUM: begin
                    r_acc <= acc_n;
                    if (last_prev) begin
                        case (desc.st)
                            zpc_pkg::ST_U:    r_u    <= acc_sat;
                            zpc_pkg::ST_NPOS: r_npos <= acc_sat;
                            zpc_pkg::ST_NVEL: r_nvel <= acc_sat;
                            zpc_pkg::ST_NACC: r_nacc <= acc_sat;
                            zpc_pkg::ST_ZMP:  r_zmp  <= acc_sat;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
        if (r_state == zpc_pkg::S_DONE && (!r_ovalid || !i_stall)) begin
            r_o_pos_x <= r_pos_x; r_o_vel_x <= r_vel_x; r_o_acc_x <= r_acc_x;
            r_o_pos_y <= r_pos_y; r_o_vel_y <= r_vel_y; r_o_acc_y <= r_acc_y;
            r_o_zmp_x <= r_zmp_x; r_o_zmp_y <= r_zmp_y;
        end
    end

    // checks
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zpc_pkg::S_CLEAR) |-> o_stall)
        else $error("request taken during clearing pass");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_ptr) < PREVIEW_DEPTH) && (32'(r_head) < PREVIEW_DEPTH))
        else $error("window pointer out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == zpc_pkg::S_DONE))
        else $error("result raised outside step completion");

    a_preview_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zpc_pkg::S_RUN && r_term != zpc_pkg::TERM_PREVIEW &&
         r_term != 4'd5) |-> (r_term < zpc_pkg::TERM_PREVIEW || r_i == LAST_IDX))
        else $error("preview walk left unfinished");

endmodule
`default_nettype wire
